// File: hdl/ttb_pkg.sv
// Shared types, constants and helpers for the tangent/bitangent block.
`timescale 1ns / 1ps

package ttb_pkg;

    // One vertex: position and texture coordinate, all signed Q16.16.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
    } in_t;

    // One triangle result.
    typedef struct packed {
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic signed [31:0] tangent_z;
        logic signed [31:0] bitangent_x;
        logic signed [31:0] bitangent_y;
        logic signed [31:0] bitangent_z;
        logic               degenerate;
    } out_t;

    localparam int DW = 33;    // width of one delta
    localparam int PW = 66;    // width of one product
    localparam int NW = 67;    // width of a difference of products
    localparam int QW = 33;    // quotient bits produced by the divider
    localparam int XW = NW + 16; // scaled numerator magnitude

    // Edge and UV deltas of one triangle, handed from front to back.
    typedef struct packed {
        logic signed [DW-1:0] dp1_x;
        logic signed [DW-1:0] dp1_y;
        logic signed [DW-1:0] dp1_z;
        logic signed [DW-1:0] dp2_x;
        logic signed [DW-1:0] dp2_y;
        logic signed [DW-1:0] dp2_z;
        logic signed [DW-1:0] du1;
        logic signed [DW-1:0] dv1;
        logic signed [DW-1:0] du2;
        logic signed [DW-1:0] dv2;
    } delta_t;

    localparam int QDEPTH = 2;

    localparam logic [3:0] MUL_LAST  = 4'd14;
    localparam logic [5:0] ITER_LAST = 6'd32;
    localparam logic [2:0] COMP_LAST = 3'd5;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_MUL,
        BS_DSET,
        BS_DITER,
        BS_OUT
    } back_state_t;

    // Sign and saturate an unsigned quotient magnitude to signed 32 bits.
    function automatic logic [31:0] sat_q(input logic [QW-1:0] mag, input logic neg);
        logic [QW-1:0] lim;
        logic [QW-1:0] m;
        begin
            lim = neg ? QW'(33'h080000000) : QW'(33'h07FFFFFFF);
            m   = (mag > lim) ? lim : mag;
            sat_q = neg ? (32'd0 - m[31:0]) : m[31:0];
        end
    endfunction

    // Exact signed difference of two 32-bit values.
    function automatic logic signed [DW-1:0] sdiff(input logic [31:0] a, input logic [31:0] b);
        begin
            sdiff = $signed({a[31], a}) - $signed({b[31], b});
        end
    endfunction

endpackage

// File: hdl/triangle_tangent_bitangent.sv
// Top level of the per-triangle tangent and bitangent unit.
`timescale 1ns / 1ps

// Vertices enter on the push side: in_data is taken at a clock edge with
// push high and full low. Every third vertex closes a triangle; the first
// two of each triangle only load holding registers and give no result.
// Results leave on the pop side: out_data holds the oldest result while
// empty is low, and a transfer happens at an edge with pop high.
// The front end takes one vertex per cycle while full is low and passes
// the triangle deltas into a two-entry queue. The back end pulls one
// triangle at a time and runs 14 products through one shared
// multiplier, then six quotients through one restoring divider that
// retires one bit per cycle. In the back end a triangle passes through
// taking the deltas, the products, division per component and the
// load of the output register.
// A degenerate triangle (zero UV determinant) skips the divider.
// While the receiver stalls, the finished result waits in the output
// register, the back end holds its next result, the queue fills, and
// full then rises on the third vertex of a triangle.
// Reset empties the queue and output register and starts a new triangle.

module triangle_tangent_bitangent (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  ttb_pkg::in_t  in_data,
    output logic          empty,
    input  logic          pop,
    output ttb_pkg::out_t out_data
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_valid;
    ttb_pkg::delta_t q_wdata;
    ttb_pkg::delta_t q_rdata;

    ttb_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_data (in_data),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_data  (q_wdata)
    );

    ttb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_data (q_wdata),
        .q_full  (q_full),
        .rd      (q_pop),
        .q_valid (q_valid),
        .rd_data (q_rdata)
    );

    ttb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("delta queue written while full");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("delta queue read while empty");

    a_full_queue: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_full)
        else $error("input stalled with room in the queue");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_data)))
        else $error("waiting result changed before transfer");

endmodule

// File: hdl/ttb_front.sv
// Front end: collects three vertices and forms the triangle deltas.
`timescale 1ns / 1ps

module ttb_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  ttb_pkg::in_t    in_data,
    output logic            q_push,
    input  logic            q_full,
    output ttb_pkg::delta_t q_data
);

    logic [1:0]   slot_reg;
    logic [1:0]   slot_next;
    ttb_pkg::in_t v0_reg;
    ttb_pkg::in_t v1_reg;
    logic         take;

    // The third vertex can only be taken when the queue has room.
    assign full   = (slot_reg == 2'd2) && q_full;
    assign take   = push && !full;
    assign q_push = take && (slot_reg == 2'd2);

    always_comb
    begin
        slot_next = slot_reg;
        if (take)
        begin
            slot_next = (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= 2'd0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && (slot_reg == 2'd0))
        begin
            v0_reg <= in_data;
        end
        if (take && (slot_reg == 2'd1))
        begin
            v1_reg <= in_data;
        end
    end

    always_comb
    begin
        q_data.dp1_x = ttb_pkg::sdiff(v1_reg.pos_x, v0_reg.pos_x);
        q_data.dp1_y = ttb_pkg::sdiff(v1_reg.pos_y, v0_reg.pos_y);
        q_data.dp1_z = ttb_pkg::sdiff(v1_reg.pos_z, v0_reg.pos_z);
        q_data.dp2_x = ttb_pkg::sdiff(in_data.pos_x, v0_reg.pos_x);
        q_data.dp2_y = ttb_pkg::sdiff(in_data.pos_y, v0_reg.pos_y);
        q_data.dp2_z = ttb_pkg::sdiff(in_data.pos_z, v0_reg.pos_z);
        q_data.du1   = ttb_pkg::sdiff(v1_reg.tex_u, v0_reg.tex_u);
        q_data.dv1   = ttb_pkg::sdiff(v1_reg.tex_v, v0_reg.tex_v);
        q_data.du2   = ttb_pkg::sdiff(in_data.tex_u, v0_reg.tex_u);
        q_data.dv2   = ttb_pkg::sdiff(in_data.tex_v, v0_reg.tex_v);
    end

endmodule

// File: hdl/ttb_queue.sv
// Short queue of triangle deltas between front and back.
`timescale 1ns / 1ps

module ttb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  ttb_pkg::delta_t wr_data,
    output logic            q_full,
    input  logic            rd,
    output logic            q_valid,
    output ttb_pkg::delta_t rd_data
);

    ttb_pkg::delta_t mem [ttb_pkg::QDEPTH];
    logic            wp_reg;
    logic            rp_reg;
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;

    assign q_full  = (cnt_reg == 2'(ttb_pkg::QDEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign rd_data = mem[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

endmodule

// File: hdl/ttb_back.sv
// Back end: shared multiplier, restoring divider and result register.
`timescale 1ns / 1ps

module ttb_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  ttb_pkg::delta_t q_data,
    output logic            q_pop,
    output logic            empty,
    input  logic            pop,
    output ttb_pkg::out_t   out_data
);

    ttb_pkg::back_state_t state_reg;
    ttb_pkg::back_state_t state_next;

    ttb_pkg::delta_t d_reg;
    logic [3:0]      mstep_reg;
    logic [2:0]      comp_reg;
    logic [5:0]      iter_reg;
    logic            ov_reg;

    logic signed [ttb_pkg::PW-1:0] prod_reg;
    logic signed [ttb_pkg::PW-1:0] acc_reg;
    logic signed [ttb_pkg::NW-1:0] det_reg;
    logic signed [ttb_pkg::NW-1:0] num_reg [6];
    logic [ttb_pkg::NW-1:0]        dabs_reg;
    logic [ttb_pkg::NW-1:0]        rem_reg;
    logic [ttb_pkg::QW-1:0]        nlo_reg;
    logic [ttb_pkg::QW-1:0]        q_reg;
    logic                          neg_reg;
    logic                          degen_reg;
    logic [31:0]                   res_reg [6];
    ttb_pkg::out_t                 out_reg;

    logic signed [ttb_pkg::DW-1:0] opa;
    logic signed [ttb_pkg::DW-1:0] opb;
    logic [2:0]                    term;
    logic [3:0]                    prev;
    logic signed [ttb_pkg::NW-1:0] diff;

    logic signed [ttb_pkg::NW-1:0] cur_num;
    logic [ttb_pkg::NW-1:0]        mag;
    logic [ttb_pkg::XW-1:0]        nabs;
    logic [ttb_pkg::XW-ttb_pkg::QW-1:0] hi;
    logic                          sat_now;
    logic                          neg_now;
    logic [ttb_pkg::NW:0]          r2;
    logic                          ge;
    logic [ttb_pkg::QW-1:0]        q_new;

    logic ob_free;
    logic ob_load;
    logic mul_done;
    logic det_zero;

    assign ob_free  = !ov_reg || pop;
    assign mul_done = (mstep_reg == ttb_pkg::MUL_LAST);
    assign det_zero = (det_reg == '0);

    // Product schedule: pairs of products for det, three tangent and three
    // bitangent numerators, each pair subtracted as first minus second.
    assign term = mstep_reg[3:1];
    always_comb
    begin
        opa = '0;
        opb = '0;
        unique case (term)
            3'd0:
            begin
                opa = mstep_reg[0] ? d_reg.du2 : d_reg.du1;
                opb = mstep_reg[0] ? d_reg.dv1 : d_reg.dv2;
            end
            3'd1:
            begin
                opa = mstep_reg[0] ? d_reg.dv1 : d_reg.dv2;
                opb = mstep_reg[0] ? d_reg.dp2_x : d_reg.dp1_x;
            end
            3'd2:
            begin
                opa = mstep_reg[0] ? d_reg.dv1 : d_reg.dv2;
                opb = mstep_reg[0] ? d_reg.dp2_y : d_reg.dp1_y;
            end
            3'd3:
            begin
                opa = mstep_reg[0] ? d_reg.dv1 : d_reg.dv2;
                opb = mstep_reg[0] ? d_reg.dp2_z : d_reg.dp1_z;
            end
            3'd4:
            begin
                opa = mstep_reg[0] ? d_reg.du2 : d_reg.du1;
                opb = mstep_reg[0] ? d_reg.dp1_x : d_reg.dp2_x;
            end
            3'd5:
            begin
                opa = mstep_reg[0] ? d_reg.du2 : d_reg.du1;
                opb = mstep_reg[0] ? d_reg.dp1_y : d_reg.dp2_y;
            end
            3'd6:
            begin
                opa = mstep_reg[0] ? d_reg.du2 : d_reg.du1;
                opb = mstep_reg[0] ? d_reg.dp1_z : d_reg.dp2_z;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign prev = mstep_reg - 4'd1;
    assign diff = $signed({acc_reg[ttb_pkg::PW-1], acc_reg})
                - $signed({prod_reg[ttb_pkg::PW-1], prod_reg});

    // Divider operands for the current component.
    assign cur_num = num_reg[comp_reg];
    assign neg_now = cur_num[ttb_pkg::NW-1] ^ det_reg[ttb_pkg::NW-1];
    assign mag     = cur_num[ttb_pkg::NW-1] ? ttb_pkg::NW'(-cur_num) : cur_num;
    assign nabs    = {mag, 16'd0};
    assign hi      = nabs[ttb_pkg::XW-1:ttb_pkg::QW];
    // A quotient of 2^33 or more saturates without iterating.
    assign sat_now = {{(ttb_pkg::NW-(ttb_pkg::XW-ttb_pkg::QW)){1'b0}}, hi} >= dabs_reg;
    assign r2      = {rem_reg, nlo_reg[ttb_pkg::QW-1]};
    assign ge      = r2 >= {1'b0, dabs_reg};
    assign q_new   = {q_reg[ttb_pkg::QW-2:0], ge};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ttb_pkg::BS_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ttb_pkg::BS_MUL;
                end
            end
            ttb_pkg::BS_MUL:
            begin
                if (mul_done)
                begin
                    state_next = det_zero ? ttb_pkg::BS_OUT : ttb_pkg::BS_DSET;
                end
            end
            ttb_pkg::BS_DSET:
            begin
                if (!sat_now)
                begin
                    state_next = ttb_pkg::BS_DITER;
                end
                else if (comp_reg == ttb_pkg::COMP_LAST)
                begin
                    state_next = ttb_pkg::BS_OUT;
                end
            end
            ttb_pkg::BS_DITER:
            begin
                if (iter_reg == ttb_pkg::ITER_LAST)
                begin
                    state_next = (comp_reg == ttb_pkg::COMP_LAST) ? ttb_pkg::BS_OUT
                                                                  : ttb_pkg::BS_DSET;
                end
            end
            ttb_pkg::BS_OUT:
            begin
                if (ob_free)
                begin
                    state_next = ttb_pkg::BS_IDLE;
                end
            end
            default:
            begin
                state_next = ttb_pkg::BS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop   = (state_reg == ttb_pkg::BS_IDLE) && q_valid;
        ob_load = (state_reg == ttb_pkg::BS_OUT) && ob_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttb_pkg::BS_IDLE;
            mstep_reg <= 4'd0;
            comp_reg  <= 3'd0;
            iter_reg  <= 6'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ttb_pkg::BS_IDLE)
            begin
                mstep_reg <= 4'd0;
                comp_reg  <= 3'd0;
            end
            else if (state_reg == ttb_pkg::BS_MUL)
            begin
                mstep_reg <= mstep_reg + 4'd1;
            end
            if (state_reg == ttb_pkg::BS_DSET)
            begin
                iter_reg <= 6'd0;
                if (sat_now)
                begin
                    comp_reg <= comp_reg + 3'd1;
                end
            end
            else if (state_reg == ttb_pkg::BS_DITER)
            begin
                iter_reg <= iter_reg + 6'd1;
                if (iter_reg == ttb_pkg::ITER_LAST)
                begin
                    comp_reg <= comp_reg + 3'd1;
                end
            end
            if (ob_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (pop && ov_reg)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            d_reg <= q_data;
        end
        if (state_reg == ttb_pkg::BS_MUL)
        begin
            if (!mul_done)
            begin
                prod_reg <= opa * opb;
            end
            if (mstep_reg != 4'd0)
            begin
                if (!prev[0])
                begin
                    acc_reg <= prod_reg;
                end
                else if (prev[3:1] == 3'd0)
                begin
                    det_reg <= diff;
                end
                else
                begin
                    num_reg[prev[3:1] - 3'd1] <= diff;
                end
            end
            dabs_reg  <= det_reg[ttb_pkg::NW-1] ? ttb_pkg::NW'(-det_reg) : det_reg;
            degen_reg <= det_zero;
        end
        if (state_reg == ttb_pkg::BS_DSET)
        begin
            neg_reg <= neg_now;
            rem_reg <= {{(ttb_pkg::NW-(ttb_pkg::XW-ttb_pkg::QW)){1'b0}}, hi};
            nlo_reg <= nabs[ttb_pkg::QW-1:0];
            q_reg   <= '0;
            if (sat_now)
            begin
                res_reg[comp_reg] <= ttb_pkg::sat_q('1, neg_now);
            end
        end
        if (state_reg == ttb_pkg::BS_DITER)
        begin
            rem_reg <= ge ? ttb_pkg::NW'(r2 - {1'b0, dabs_reg}) : r2[ttb_pkg::NW-1:0];
            nlo_reg <= {nlo_reg[ttb_pkg::QW-2:0], 1'b0};
            q_reg   <= q_new;
            if (iter_reg == ttb_pkg::ITER_LAST)
            begin
                res_reg[comp_reg] <= ttb_pkg::sat_q(q_new, neg_reg);
            end
        end
        if (ob_load)
        begin
            out_reg.tangent_x   <= degen_reg ? '0 : res_reg[0];
            out_reg.tangent_y   <= degen_reg ? '0 : res_reg[1];
            out_reg.tangent_z   <= degen_reg ? '0 : res_reg[2];
            out_reg.bitangent_x <= degen_reg ? '0 : res_reg[3];
            out_reg.bitangent_y <= degen_reg ? '0 : res_reg[4];
            out_reg.bitangent_z <= degen_reg ? '0 : res_reg[5];
            out_reg.degenerate  <= degen_reg;
        end
    end

    assign empty    = !ov_reg;
    assign out_data = out_reg;

endmodule

// File: bench/ttb_checker.sv
// Checker for the tangent/bitangent block: predicts results and compares transfers.
`timescale 1ns / 1ps

module ttb_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          full,
    input  ttb_pkg::in_t  in_data,
    input  logic          empty,
    input  logic          pop,
    input  ttb_pkg::out_t out_data,
    output int            fail_count,
    output int            pending_count
);

    ttb_pkg::out_t triangle_results[$];
    logic [1:0] vertex_slot;
    ttb_pkg::in_t held_vertex [2];

    // Truncated Q16.16 quotient num * 2^16 / den, saturated to 32 bits.
    function automatic logic [31:0] scaled_quotient(input logic signed [127:0] num,
                                                    input logic signed [127:0] den);
        logic signed [127:0] q;
        begin
            q = (num <<< 16) / den;
            if (q > 128'sh7FFFFFFF)
                scaled_quotient = 32'h7FFFFFFF;
            else if (q < -128'sh80000000)
                scaled_quotient = 32'h80000000;
            else
                scaled_quotient = q[31:0];
        end
    endfunction

    function automatic ttb_pkg::out_t triangle_vectors(input ttb_pkg::in_t v0,
                                                       input ttb_pkg::in_t v1,
                                                       input ttb_pkg::in_t v2);
        logic signed [127:0] dp1 [3];
        logic signed [127:0] dp2 [3];
        logic signed [127:0] du1, dv1, du2, dv2, det, t, b;
        logic signed [31:0] p0 [3];
        logic signed [31:0] p1 [3];
        logic signed [31:0] p2 [3];
        logic [31:0] tc [3];
        logic [31:0] bc [3];
        ttb_pkg::out_t r;
        begin
            p0 = '{v0.pos_x, v0.pos_y, v0.pos_z};
            p1 = '{v1.pos_x, v1.pos_y, v1.pos_z};
            p2 = '{v2.pos_x, v2.pos_y, v2.pos_z};
            for (int k = 0; k < 3; k++)
            begin
                dp1[k] = 128'(p1[k]) - 128'(p0[k]);
                dp2[k] = 128'(p2[k]) - 128'(p0[k]);
            end
            du1 = 128'(v1.tex_u) - 128'(v0.tex_u);
            dv1 = 128'(v1.tex_v) - 128'(v0.tex_v);
            du2 = 128'(v2.tex_u) - 128'(v0.tex_u);
            dv2 = 128'(v2.tex_v) - 128'(v0.tex_v);
            det = du1 * dv2 - du2 * dv1;
            r = '0;
            if (det == 0)
                r.degenerate = 1'b1;
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    t = dv2 * dp1[k] - dv1 * dp2[k];
                    b = du1 * dp2[k] - du2 * dp1[k];
                    tc[k] = scaled_quotient(t, det);
                    bc[k] = scaled_quotient(b, det);
                end
                r.tangent_x = tc[0];
                r.tangent_y = tc[1];
                r.tangent_z = tc[2];
                r.bitangent_x = bc[0];
                r.bitangent_y = bc[1];
                r.bitangent_z = bc[2];
            end
            triangle_vectors = r;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending_count = 0;
        vertex_slot = 0;
    end

    always @(posedge clk)
    begin
        ttb_pkg::out_t want;
        if (rst_n)
        begin
            if (push && !full)
            begin
                if (vertex_slot < 2)
                begin
                    held_vertex[vertex_slot] = in_data;
                    vertex_slot = vertex_slot + 1;
                end
                else
                begin
                    triangle_results.push_back(
                        triangle_vectors(held_vertex[0], held_vertex[1], in_data));
                    vertex_slot = 0;
                end
            end
            if (pop && !empty)
            begin
                if (triangle_results.size() == 0)
                begin
                    report_mismatch("unexpected transfer", 32'd1, 32'd0);
                end
                else
                begin
                    want = triangle_results.pop_front();
                    if (out_data.tangent_x !== want.tangent_x)
                        report_mismatch("tangent_x", out_data.tangent_x, want.tangent_x);
                    if (out_data.tangent_y !== want.tangent_y)
                        report_mismatch("tangent_y", out_data.tangent_y, want.tangent_y);
                    if (out_data.tangent_z !== want.tangent_z)
                        report_mismatch("tangent_z", out_data.tangent_z, want.tangent_z);
                    if (out_data.bitangent_x !== want.bitangent_x)
                        report_mismatch("bitangent_x", out_data.bitangent_x,
                                        want.bitangent_x);
                    if (out_data.bitangent_y !== want.bitangent_y)
                        report_mismatch("bitangent_y", out_data.bitangent_y,
                                        want.bitangent_y);
                    if (out_data.bitangent_z !== want.bitangent_z)
                        report_mismatch("bitangent_z", out_data.bitangent_z,
                                        want.bitangent_z);
                    if (out_data.degenerate !== want.degenerate)
                        report_mismatch("degenerate", 32'(out_data.degenerate),
                                        32'(want.degenerate));
                end
            end
            pending_count = triangle_results.size();
        end
    end
endmodule

// File: bench/testbench.sv
// Top of the tangent/bitangent bench: stimulus, result draining and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_VERTICES = 1100;
    localparam int CYCLE_LIMIT = 800000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    ttb_pkg::in_t in_data = '0;
    ttb_pkg::out_t out_data;
    int fail_count, pending_count;
    int cycle_count = 0;

    triangle_tangent_bitangent uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
        .empty(empty), .pop(pop), .out_data(out_data)
    );

    ttb_checker checker_i (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
        .empty(empty), .pop(pop), .out_data(out_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** triangle_tangent_bitangent: FAILED **");
            $finish;
        end
    end

    function automatic logic [31:0] edge_word();
        case ($urandom_range(0, 5))
            0: edge_word = 32'h7FFFFFFF;
            1: edge_word = 32'h80000000;
            2: edge_word = 32'h0;
            3: edge_word = 32'hFFFFFFFF;
            4: edge_word = 32'h00010000;
            default: edge_word = $urandom;
        endcase
    endfunction

    // Mostly small coordinates so quotients stay in range; some full-width.
    function automatic logic [31:0] coord_word(input int mode);
        if (mode == 0)
            coord_word = $urandom;
        else if (mode == 1)
            coord_word = edge_word();
        else
            coord_word = 32'($signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000);
    endfunction

    // About one draw in four gives no gap; the others draw a random gap length.
    function automatic int gap_cycles();
        gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    endfunction

    // Push stays high between back-to-back vertices and drops only for a gap or a drain.
    task automatic send_vertex(input ttb_pkg::in_t v);
        int gap;
        gap = gap_cycles();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        in_data <= v;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    function automatic ttb_pkg::in_t random_vertex(input int mode);
        ttb_pkg::in_t v;
        v.pos_x = coord_word(mode);
        v.pos_y = coord_word(mode);
        v.pos_z = coord_word(mode);
        v.tex_u = coord_word(mode);
        v.tex_v = coord_word(mode);
        return v;
    endfunction

    // Receiver: draws a stall before each transfer.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = gap_cycles();
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
        end
    end

    initial
    begin
        ttb_pkg::in_t v;
        int mode;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Degenerate triangle: identical texture coordinates.
        v = '{32'h00010000, 32'h0, 32'h0, 32'h00010000, 32'h00010000};
        repeat (3) send_vertex(v);
        // Unit right triangle with matching UVs.
        send_vertex('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        send_vertex('{32'h00010000, 32'h0, 32'h0, 32'h00010000, 32'h0});
        send_vertex('{32'h0, 32'h00010000, 32'h0, 32'h0, 32'h00010000});
        // Saturation: huge edges over a tiny UV area give positive saturation; then huge edges over a huge UV area.
        send_vertex('{32'h80000000, 32'h80000000, 32'h80000000, 32'h0, 32'h0});
        send_vertex('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h1, 32'h0});
        send_vertex('{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h1});
        send_vertex('{32'h7FFFFFFF, 32'h0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000});
        send_vertex('{32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF});
        send_vertex('{32'hFFFFFFFF, 32'h80000000, 32'h1, 32'h80000000, 32'h80000000});
        // Extreme values in every field.
        for (int i = 0; i < 6; i++)
            send_vertex('{edge_word(), edge_word(), edge_word(), edge_word(), edge_word()});

        // Hold off until the block has drained.
        drain_results();

        for (int i = 0; i < RANDOM_VERTICES; i++)
        begin
            mode = $urandom_range(0, 9);
            mode = (mode == 0) ? 0 : (mode == 1) ? 1 : 2;
            // Occasionally repeat the previous UV; within one triangle this forces a degenerate one.
            if ($urandom_range(0, 15) == 0)
            begin
                v.pos_x = $urandom;
                send_vertex(v);
            end
            else
            begin
                v = random_vertex(mode);
                send_vertex(v);
            end
            if (i == RANDOM_VERTICES / 2)
                drain_results();
        end
        // Trailing vertex: closes the last triangle of the random run.
        send_vertex(random_vertex(2));

        drain_results();
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("** triangle_tangent_bitangent: PASSED **");
        else
            $display("** triangle_tangent_bitangent: FAILED **");
        $finish;
    end
endmodule
